// ----- hdl/bdl_pkg.sv -----
// shared types and constants of the button debounce and long-press block
// depends on nothing; every other file of the block imports it
`timescale 1ns / 1ps

package bdl_pkg;

	// default number of buttons
	localparam int BDL_NUM_BUTTONS = 2;

	// configuration register indexes
	localparam logic [7:0] REG_DEBOUNCE  = 8'd0;
	localparam logic [7:0] REG_LONG_MS   = 8'd1;
	localparam logic [7:0] REG_ENABLE    = 8'd2;
	localparam logic [7:0] REG_ACTIVE_HI = 8'd3;

	// reset values of the registers
	localparam logic [7:0]  DEBOUNCE_RST = 8'd3;
	localparam logic [15:0] LONG_MS_RST  = 16'd1000;

	// event codes
	typedef enum logic [1:0] {
		EV_PRESS   = 2'd0,
		EV_RELEASE = 2'd1,
		EV_LONG    = 2'd2
	} evk_t;

	// event raised by one lane for one sample
	typedef struct packed {
		logic        vld;
		evk_t        kind;
		logic [31:0] held;
	} ev_t;

	// settings common to all lanes
	typedef struct packed {
		logic [7:0]  debounce;
		logic [15:0] long_ms;
	} cfg_t;

endpackage

// ----- hdl/bdl_lane.sv -----
// one button lane: debounce counter, press and long-press tracking
// depends on bdl_pkg
`timescale 1ns / 1ps

module bdl_lane
	import bdl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fire,
	input  logic        primed,
	input  logic        en,
	input  logic        act,
	input  logic        lvl,
	input  logic [31:0] now,
	input  cfg_t        cfg,
	output ev_t         ev,
	output logic        down_next
);

	logic        deb_q, deb_d;
	logic [7:0]  mm_q, mm_d;
	logic        prep_q, prep_d;
	logic        lrep_q, lrep_d;
	logic [31:0] ptime_q, ptime_d;

	logic        down_raw;
	logic        differ;
	logic        take;
	logic [7:0]  mm_inc;
	logic [15:0] thresh;
	logic [31:0] held;

	// next state and event for the sample at hand
	always_comb begin
		down_raw = act ? lvl : ~lvl;
		mm_inc   = mm_q + 8'd1;
		thresh   = (cfg.long_ms == 16'd0) ? 16'd1 : cfg.long_ms;
		held     = now - ptime_q;
		differ   = down_raw != deb_q;
		take     = differ && (mm_inc >= cfg.debounce);

		deb_d   = deb_q;
		mm_d    = mm_q;
		prep_d  = prep_q;
		lrep_d  = lrep_q;
		ptime_d = ptime_q;
		ev.vld  = 1'b0;
		ev.kind = EV_PRESS;
		ev.held = '0;

		if (!primed) begin
			// first sample only primes the state
			deb_d   = en && down_raw;
			mm_d    = '0;
			prep_d  = 1'b0;
			lrep_d  = 1'b1;
			ptime_d = now;
		end else if (en) begin
			if (differ) begin
				mm_d = mm_inc;
			end else begin
				mm_d = '0;
			end
			if (take) begin
				mm_d   = '0;
				deb_d  = down_raw;
				lrep_d = 1'b0;
				if (down_raw) begin
					ptime_d = now;
					prep_d  = 1'b1;
					ev.vld  = 1'b1;
					ev.kind = EV_PRESS;
				end else begin
					// release is reported only for a reported press
					ev.vld  = prep_q;
					ev.kind = EV_RELEASE;
					ev.held = held;
					prep_d  = 1'b0;
				end
			end else if (deb_q && !lrep_q && (held >= {16'd0, thresh})) begin
				lrep_d  = 1'b1;
				ev.vld  = 1'b1;
				ev.kind = EV_LONG;
				ev.held = held;
			end
		end
		down_next = deb_d;
	end

	// lane state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deb_q   <= 1'b0;
			mm_q    <= '0;
			prep_q  <= 1'b0;
			lrep_q  <= 1'b1;
			ptime_q <= '0;
		end else if (fire) begin
			deb_q   <= deb_d;
			mm_q    <= mm_d;
			prep_q  <= prep_d;
			lrep_q  <= lrep_d;
			ptime_q <= ptime_d;
		end
	end

endmodule

// ----- hdl/bdl_merge.sv -----
// merging stage: picks the first two lane events and drains them one per transfer
// depends on bdl_pkg
`timescale 1ns / 1ps

module bdl_merge
	import bdl_pkg::*;
#(
	parameter int NUM_BUTTONS = BDL_NUM_BUTTONS,
	parameter int BTN_W       = 1,
	parameter int OUT_W       = 40
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   fire,
	input  ev_t                    ev [NUM_BUTTONS],
	input  logic [NUM_BUTTONS-1:0] down_next,
	output logic                   free,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_W-1:0]       m_tdata,  // button, held_ms, pressed_now
	output logic [1:0]             m_tuser,  // event_kind
	output logic                   m_tlast
);

	logic [1:0]             num_s2;
	logic                   head_s2;
	logic [BTN_W-1:0]       btn_s2  [2];
	evk_t                   kind_s2 [2];
	logic [31:0]            held_s2 [2];
	logic [NUM_BUTTONS-1:0] pressed_s2;

	logic             f0, f1;
	logic [BTN_W-1:0] b0, b1;
	evk_t             k0, k1;
	logic [31:0]      h0, h1;
	logic [1:0]       num_new;
	logic             xfer;
	logic             load;

	// first and second event in lane order; later ones are dropped
	always_comb begin
		f0 = 1'b0;
		f1 = 1'b0;
		b0 = '0;
		b1 = '0;
		k0 = EV_PRESS;
		k1 = EV_PRESS;
		h0 = '0;
		h1 = '0;
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			if (ev[i].vld) begin
				if (!f0) begin
					f0 = 1'b1;
					b0 = BTN_W'(i);
					k0 = ev[i].kind;
					h0 = ev[i].held;
				end else if (!f1) begin
					f1 = 1'b1;
					b1 = BTN_W'(i);
					k1 = ev[i].kind;
					h1 = ev[i].held;
				end
			end
		end
		num_new = {1'b0, f0} + {1'b0, f1};
	end

	// output side
	assign m_tvalid = num_s2 != 2'd0;
	assign m_tlast  = head_s2 || (num_s2 == 2'd1);
	assign m_tdata  = OUT_W'({pressed_s2, held_s2[head_s2], btn_s2[head_s2]});
	assign m_tuser  = kind_s2[head_s2];
	assign xfer     = m_tvalid && m_tready;
	assign free     = !m_tvalid || (xfer && m_tlast);
	assign load     = fire && (num_new != 2'd0);

	// buffer occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_s2  <= '0;
			head_s2 <= 1'b0;
		end else begin
			if (xfer) begin
				if (m_tlast) begin
					num_s2  <= '0;
					head_s2 <= 1'b0;
				end else begin
					head_s2 <= 1'b1;
				end
			end
			if (load) begin
				num_s2  <= num_new;
				head_s2 <= 1'b0;
			end
		end
	end

	// event payload
	always_ff @(posedge clk) begin
		if (load) begin
			btn_s2[0]  <= b0;
			kind_s2[0] <= k0;
			held_s2[0] <= h0;
			btn_s2[1]  <= b1;
			kind_s2[1] <= k1;
			held_s2[1] <= h1;
			pressed_s2 <= down_next;
		end
	end

endmodule

// ----- hdl/button_debounce_longpress.sv -----
// top level of the button debounce and long-press block
// depends on bdl_pkg, bdl_lane and bdl_merge
`timescale 1ns / 1ps

// Each input transfer is one poll sample: the pad level of every button and
// a millisecond timestamp. One lane per button debounces its level, times
// the hold and raises PRESS, RELEASE or LONGPRESS; the merging stage keeps
// the first two events in button order and sends them one transfer each,
// tlast on the final event of a sample. The first sample after reset only
// primes the lanes. A sample passes an input register and then the output
// register, which it enters once the output buffer is free. A sample is taken
// every cycle while the output drains at the same pace; one that raises two
// events holds the two-entry output buffer for two transfers, so the
// sustained rate is one sample per cycle for up to one event, while after two
// events the next sample waits until the second is taken. Configuration
// writes are always taken (cfg_ready is high) and belong to times when no
// sample is in flight.
module button_debounce_longpress
	import bdl_pkg::*;
#(
	parameter int NUM_BUTTONS = BDL_NUM_BUTTONS,
	localparam int BTN_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1,
	localparam int IN_W  = ((NUM_BUTTONS + 32 + 7) / 8) * 8,
	localparam int OUT_W = ((BTN_W + 32 + NUM_BUTTONS + 7) / 8) * 8,
	localparam int CFG_W = (NUM_BUTTONS > 16) ? NUM_BUTTONS : 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // pad_levels, now_ms
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,   // button, held_ms, pressed_now
	output logic [1:0]       m_tuser,   // event_kind
	output logic             m_tlast,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [7:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	logic [7:0]             debounce_q;
	logic [15:0]            long_ms_q;
	logic [NUM_BUTTONS-1:0] enable_q;
	logic [NUM_BUTTONS-1:0] active_hi_q;
	logic                   primed_q;

	logic                   valid_s1;
	logic [NUM_BUTTONS-1:0] pad_s1;
	logic [31:0]            now_s1;

	logic                   free;
	logic                   fire;
	cfg_t                   cfg;
	ev_t                    ev [NUM_BUTTONS];
	logic [NUM_BUTTONS-1:0] down_next;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q  <= DEBOUNCE_RST;
			long_ms_q   <= LONG_MS_RST;
			enable_q    <= '1;
			active_hi_q <= '1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_DEBOUNCE:  debounce_q  <= cfg_data[7:0];
				REG_LONG_MS:   long_ms_q   <= cfg_data[15:0];
				REG_ENABLE:    enable_q    <= cfg_data[NUM_BUTTONS-1:0];
				REG_ACTIVE_HI: active_hi_q <= cfg_data[NUM_BUTTONS-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.debounce = debounce_q;
	assign cfg.long_ms  = long_ms_q;

	// input register
	assign fire     = valid_s1 && free;
	assign s_tready = !valid_s1 || free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			primed_q <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				valid_s1 <= 1'b1;
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
			if (fire) begin
				primed_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			pad_s1 <= s_tdata[NUM_BUTTONS-1:0];
			now_s1 <= s_tdata[NUM_BUTTONS+31:NUM_BUTTONS];
		end
	end

	// one lane per button
	for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
		bdl_lane u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.fire      (fire),
			.primed    (primed_q),
			.en        (enable_q[g]),
			.act       (active_hi_q[g]),
			.lvl       (pad_s1[g]),
			.now       (now_s1),
			.cfg       (cfg),
			.ev        (ev[g]),
			.down_next (down_next[g])
		);
	end

	// event merge and output buffer
	bdl_merge #(
		.NUM_BUTTONS (NUM_BUTTONS),
		.BTN_W       (BTN_W),
		.OUT_W       (OUT_W)
	) u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.ev        (ev),
		.down_next (down_next),
		.free      (free),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

// ----- bench/tb_button_debounce_longpress.sv -----
// testbench for button_debounce_longpress: directed and random poll samples,
// events predicted in the bench and checked in order; depends on bdl_pkg and the RTL
`timescale 1ns / 1ps

module tb_button_debounce_longpress
	import bdl_pkg::*;
();

	localparam int SAMPLE_W = 40;	// pad_levels, now_ms, zero fill
	localparam int EVENT_W  = 40;	// button, held_ms, pressed_now, zero fill
	localparam int CFG_W    = 16;
	localparam int HOLD_OFF = 400;

	typedef struct {
		bit        btn;
		evk_t      kind;
		bit [31:0] held;
		bit [1:0]  pressed;
		bit        last;
	} btn_event_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [SAMPLE_W-1:0] s_tdata = '0;	// pad_levels, now_ms
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [EVENT_W-1:0]  m_tdata;	// button, held_ms, pressed_now
	logic [1:0]          m_tuser;	// event_kind
	logic                m_tlast;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [7:0]          cfg_index = '0;
	logic [CFG_W-1:0]    cfg_data = '0;

	button_debounce_longpress dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	// settings as the block should hold them
	bit [7:0]  set_debounce = DEBOUNCE_RST;
	bit [15:0] set_long_ms = LONG_MS_RST;
	bit [1:0]  set_enable = 2'b11;
	bit [1:0]  set_active_hi = 2'b11;

	// per-button debounce state
	bit        primed = 1'b0;
	bit [1:0]  down = '0;
	bit [1:0]  press_rep = '0;
	bit [1:0]  long_rep = 2'b11;
	bit [7:0]  miss_cnt [2] = '{8'd0, 8'd0};
	bit [31:0] t_press [2] = '{32'd0, 32'd0};

	btn_event_t expected_events[$];
	int         errors = 0;
	int         idle_pct = 0;
	int         stall_pct = 0;
	int         hold_target = 0;
	int         hold_count = 0;
	bit [31:0]  clock_ms = '0;

	function automatic btn_event_t make_event(bit b, evk_t kind, bit [31:0] held);
		btn_event_t ev;
		ev.btn = b;
		ev.kind = kind;
		ev.held = held;
		ev.pressed = '0;
		ev.last = 1'b0;
		return ev;
	endfunction

	// update button state for one sample and queue the events it raises
	function automatic void predict_events(bit [1:0] pads, bit [31:0] now);
		btn_event_t found[$];
		bit [31:0]  thresh;
		bit [31:0]  since;
		bit         raw;
		thresh = (set_long_ms == 16'd0) ? 32'd1 : {16'd0, set_long_ms};
		for (int b = 0; b < 2; b++) begin
			raw = set_active_hi[b] ? pads[b] : ~pads[b];
			if (!primed) begin
				down[b] = set_enable[b] & raw;
				miss_cnt[b] = '0;
				press_rep[b] = 1'b0;
				long_rep[b] = 1'b1;
				t_press[b] = now;
				continue;
			end
			if (!set_enable[b])
				continue;
			if (raw != down[b]) begin
				miss_cnt[b] = miss_cnt[b] + 8'd1;
				// a zero count behaves as one
				if (miss_cnt[b] >= set_debounce) begin
					miss_cnt[b] = '0;
					down[b] = raw;
					long_rep[b] = 1'b0;
					if (raw) begin
						t_press[b] = now;
						press_rep[b] = 1'b1;
						found.push_back(make_event(1'(b), EV_PRESS, 32'd0));
					end else begin
						// release only reported when its press was
						if (press_rep[b])
							found.push_back(make_event(1'(b), EV_RELEASE,
								now - t_press[b]));
						press_rep[b] = 1'b0;
					end
				end
			end else begin
				miss_cnt[b] = '0;
			end
			since = now - t_press[b];
			if (down[b] && !long_rep[b] && since >= thresh) begin
				long_rep[b] = 1'b1;
				found.push_back(make_event(1'(b), EV_LONG, since));
			end
		end
		primed = 1'b1;
		for (int k = 0; k < found.size(); k++) begin
			found[k].pressed = down;
			found[k].last = (k == found.size() - 1);
			expected_events.push_back(found[k]);
		end
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch in %s at %0t: got %0h, want %0h", what, $realtime, got, want);
		errors++;
	endtask

	// receiver readiness: long hold-off on request, otherwise random stalls
	always @(posedge clk) begin
		if (hold_count < hold_target) begin
			hold_count <= hold_count + 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// compare each output transfer with the oldest expected event
	always @(posedge clk) begin : check_events
		btn_event_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_events.size() == 0) begin
				report_mismatch("unexpected event", m_tdata, '0);
			end else begin
				want = expected_events.pop_front();
				if (m_tdata[0] != want.btn)
					report_mismatch("button", m_tdata[0], want.btn);
				if (m_tuser != want.kind)
					report_mismatch("event_kind", m_tuser, want.kind);
				if (m_tdata[32:1] != want.held)
					report_mismatch("held_ms", m_tdata[32:1], want.held);
				if (m_tdata[34:33] != want.pressed)
					report_mismatch("pressed_now", m_tdata[34:33], want.pressed);
				if (m_tlast != want.last)
					report_mismatch("last", m_tlast, want.last);
			end
		end
	end

	// offer one sample, with a random gap first, and wait for its transfer
	task automatic send_sample(bit [1:0] pads, bit [31:0] now);
		if ($urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'd0, now, pads};
		do @(posedge clk); while (!s_tready);
		predict_events(pads, now);
	endtask

	task automatic tick(bit [31:0] delta, bit [1:0] pads);
		clock_ms = clock_ms + delta;
		send_sample(pads, clock_ms);
	endtask

	// stop offering and wait until the block is empty
	task automatic settle();
		s_tvalid <= 1'b0;
		while (expected_events.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic cfg_write(bit [7:0] idx, bit [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_DEBOUNCE:  set_debounce = value[7:0];
			REG_LONG_MS:   set_long_ms = value;
			REG_ENABLE:    set_enable = value[1:0];
			REG_ACTIVE_HI: set_active_hi = value[1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic configure(bit [7:0] deb, bit [15:0] long_ms, bit [1:0] en, bit [1:0] act);
		cfg_write(REG_DEBOUNCE, {8'd0, deb});
		cfg_write(REG_LONG_MS, long_ms);
		cfg_write(REG_ENABLE, {14'd0, en});
		cfg_write(REG_ACTIVE_HI, {14'd0, act});
	endtask

	// priming, unreported press, double press, long press and release at reset settings
	task automatic test_reset_defaults();
		clock_ms = 32'd5000;
		send_sample(2'b01, clock_ms);
		tick(2000, 2'b01);
		repeat (3) tick(10, 2'b00);
		repeat (3) tick(10, 2'b11);
		tick(999, 2'b11);
		tick(1, 2'b11);
		tick(5, 2'b00);
		tick(5, 2'b11);
		repeat (3) tick(10, 2'b00);
	endtask

	// zero count and threshold, active low, disabled button, top threshold, time wrap
	task automatic test_special_settings();
		settle();
		configure(8'd0, 16'd0, 2'b11, 2'b00);
		tick(10, 2'b11);
		tick(10, 2'b10);
		tick(1, 2'b10);
		tick(7, 2'b11);
		settle();
		configure(8'd1, 16'hFFFF, 2'b10, 2'b11);
		tick(3, 2'b11);
		tick(32'd65534, 2'b11);
		tick(1, 2'b11);
		tick(4, 2'b01);
		settle();
		configure(8'd1, 16'd1000, 2'b11, 2'b11);
		clock_ms = 32'hFFFF_FFF0;
		tick(0, 2'b01);
		tick(32'h20, 2'b00);
	endtask

	// largest debounce count, with one broken run in front
	task automatic test_slow_debounce();
		settle();
		configure(8'd255, 16'd1000, 2'b11, 2'b11);
		repeat (20) tick(1, 2'b10);
		tick(1, 2'b00);
		repeat (254) tick(1, 2'b10);
		tick(1, 2'b10);
	endtask

	// receiver holds off while every sample raises two events
	task automatic test_back_pressure();
		settle();
		configure(8'd1, 16'd1, 2'b11, 2'b11);
		idle_pct = 0;
		stall_pct = 0;
		hold_target = hold_count + HOLD_OFF;
		repeat (20) begin
			tick(1, 2'b11);
			tick(1, 2'b00);
		end
		settle();
	endtask

	// random settings, then mostly clean press runs with glitches and noise
	task automatic test_random_phase(int idle, int stall);
		int        deb;
		int        run_left [2];
		bit [1:0]  level;
		bit [1:0]  pads;
		idle_pct = idle;
		stall_pct = stall;
		repeat (2) begin
			settle();
			configure($urandom_range(0, 5) == 0 ? 8'($urandom_range(0, 1)) :
					8'($urandom_range(2, 4)),
				$urandom_range(0, 5) == 0 ? 16'($urandom_range(0, 1)) :
					$urandom_range(0, 9) == 0 ? 16'hFFFF : 16'($urandom_range(20, 300)),
				$urandom_range(0, 3) == 0 ? 2'($urandom_range(0, 3)) : 2'b11,
				2'($urandom_range(0, 3)));
			deb = (set_debounce == 8'd0) ? 1 : set_debounce;
			level = 2'($urandom_range(0, 3));
			run_left = '{0, 0};
			if ($urandom_range(0, 3) == 0)
				clock_ms = 32'hFFFF_FF00;
			repeat (10) begin
				for (int b = 0; b < 2; b++) begin
					if (run_left[b] == 0) begin
						level[b] = ~level[b];
						run_left[b] = ($urandom_range(0, 4) == 0) ? $urandom_range(1, deb) :
							deb + $urandom_range(0, 8);
					end
					run_left[b]--;
				end
				pads = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3)) : level;
				tick(($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 60), pads);
			end
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_special_settings();
		test_slow_debounce();
		test_back_pressure();
		test_random_phase(0, 0);
		test_random_phase(51, 0);
		test_random_phase(0, 51);
		test_random_phase(14, 14);
		settle();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// watchdog
	initial begin
		#4_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule

// ----- button_debounce_longpress.f -----
hdl/bdl_pkg.sv
hdl/bdl_lane.sv
hdl/bdl_merge.sv
hdl/button_debounce_longpress.sv
bench/tb_button_debounce_longpress.sv
